// ===== rtl/dbcfd_pkg.sv =====
// Shared types and constants for the double-buffered color frame store.
package dbcfd_pkg;

  localparam int MAX_COLS_DEF   = 32;
  localparam int MAX_ROWS_DEF   = 32;
  localparam int COLOR_BITS_DEF = 4;

  // Widest grid that the dimension registers and the change mask can describe.
  localparam int GRID_LIMIT = 32;

  localparam logic [5:0] COLS_RESET = 6'd20;
  localparam logic [5:0] ROWS_RESET = 6'd20;

  localparam logic [3:0] BLACK = 4'd0;

  typedef enum logic [1:0] {
    KIND_FILL   = 2'd0,
    KIND_READ   = 2'd1,
    KIND_COMMIT = 2'd2,
    KIND_SCAN   = 2'd3
  } kind_t;

  typedef enum logic {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FILL = 4'b0010,
    S_READ = 4'b0100,
    S_SCAN = 4'b1000
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [4:0] pos_x;
    logic [4:0] pos_y;
    logic [5:0] rect_width;
    logic [5:0] rect_height;
    logic [3:0] fill_color;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  row_index;
    logic [31:0] change_mask;
    logic [3:0]  read_color;
    logic        out_of_range;
    logic        last;
  } out_item_t;

  // Row addresses are carried at the widest supported depth and cut down in the memory.
  typedef struct packed {
    logic       rd_en;
    logic [5:0] rd_row;
    logic       wr_en;
    logic [5:0] wr_row;
    logic       commit;
  } mem_ctl_t;

endpackage

// ===== rtl/dbcfd_in_if.sv =====
// Command channel interface: valid/ready handshake with one command per transaction.
interface dbcfd_in_if;
  logic               valid;
  logic               ready;
  dbcfd_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/dbcfd_out_if.sv =====
// Result channel interface: valid/ready handshake with one result per transaction.
interface dbcfd_out_if;
  logic                valid;
  logic                ready;
  dbcfd_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/dbcfd_frame_mem.sv =====
// Two row-organized frame banks that swap roles on commit, with per-row valid bits.
module dbcfd_frame_mem #(
  parameter int MAX_ROWS = dbcfd_pkg::MAX_ROWS_DEF,
  parameter int ROW_W    = dbcfd_pkg::MAX_COLS_DEF * dbcfd_pkg::COLOR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dbcfd_pkg::mem_ctl_t ctl,
  input  logic [ROW_W-1:0]    wr_data,
  output logic [ROW_W-1:0]    cur_row,
  output logic [ROW_W-1:0]    prev_row
);

  localparam int RA = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [ROW_W-1:0]    bank_a [MAX_ROWS];
  logic [ROW_W-1:0]    bank_b [MAX_ROWS];
  logic [ROW_W-1:0]    rd_a_r;
  logic [ROW_W-1:0]    rd_b_r;
  logic [MAX_ROWS-1:0] va_r;
  logic [MAX_ROWS-1:0] vb_r;
  logic                rd_va_r;
  logic                rd_vb_r;
  logic                sel_r;
  logic [RA-1:0]       ra;
  logic [RA-1:0]       wa;
  logic [ROW_W-1:0]    a_row;
  logic [ROW_W-1:0]    b_row;

  assign ra = ctl.rd_row[RA-1:0];
  assign wa = ctl.wr_row[RA-1:0];

  always_ff @(posedge clk) begin
    if (ctl.wr_en && !sel_r) begin
      bank_a[wa] <= wr_data;
    end
    if (ctl.wr_en && sel_r) begin
      bank_b[wa] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_a_r <= bank_a[ra];
      rd_b_r <= bank_b[ra];
    end
  end

  // sel_r low means bank A holds the current frame. A commit hands the current
  // frame over as the previous one and blanks the other bank by dropping its valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= 1'b0;
      va_r    <= '0;
      vb_r    <= '0;
      rd_va_r <= 1'b0;
      rd_vb_r <= 1'b0;
    end else begin
      if (ctl.commit) begin
        sel_r <= ~sel_r;
        if (sel_r) begin
          va_r <= '0;
        end else begin
          vb_r <= '0;
        end
      end
      if (ctl.wr_en) begin
        if (sel_r) begin
          vb_r[wa] <= 1'b1;
        end else begin
          va_r[wa] <= 1'b1;
        end
      end
      if (ctl.rd_en) begin
        rd_va_r <= va_r[ra];
        rd_vb_r <= vb_r[ra];
      end
    end
  end

  assign a_row    = rd_va_r ? rd_a_r : '0;
  assign b_row    = rd_vb_r ? rd_b_r : '0;
  assign cur_row  = sel_r ? b_row : a_row;
  assign prev_row = sel_r ? a_row : b_row;

endmodule

// ===== rtl/dbcfd_row_unit.sv =====
// Row datapath shared by the fill, read and scan commands: rectangle merge, change compare and cell select.
module dbcfd_row_unit #(
  parameter int MAX_COLS   = dbcfd_pkg::MAX_COLS_DEF,
  parameter int COLOR_BITS = dbcfd_pkg::COLOR_BITS_DEF
) (
  input  logic [MAX_COLS*COLOR_BITS-1:0] cur_row,
  input  logic [MAX_COLS*COLOR_BITS-1:0] prev_row,
  input  logic [4:0]                     px,
  input  logic [5:0]                     xe,
  input  logic [5:0]                     cols,
  input  logic [3:0]                     fill_color,
  output logic [MAX_COLS*COLOR_BITS-1:0] wr_row,
  output logic [31:0]                    change_mask,
  output logic [3:0]                     cell_color
);

  localparam int CB = COLOR_BITS;

  logic [CB-1:0] color_cb;

  assign color_cb = CB'(fill_color);

  for (genvar x = 0; x < MAX_COLS; x++) begin : g_merge
    localparam logic [6:0] XV = 7'(x);
    logic hit;
    assign hit = (7'(px) <= XV) && (XV < 7'(xe));
    assign wr_row[x*CB +: CB] = hit ? color_cb : cur_row[x*CB +: CB];
  end

  for (genvar x = 0; x < 32; x++) begin : g_mask
    if (x < MAX_COLS) begin : g_col
      assign change_mask[x] = (6'(x) < cols) &&
                              (cur_row[x*CB +: CB] != prev_row[x*CB +: CB]);
    end else begin : g_none
      assign change_mask[x] = 1'b0;
    end
  end

  always_comb begin
    cell_color = dbcfd_pkg::BLACK;
    for (int x = 0; x < MAX_COLS; x++) begin
      if (7'(x) == 7'(px)) begin
        cell_color = 4'(cur_row[x*CB +: CB]);
      end
    end
  end

endmodule

// ===== rtl/double_buffered_color_frame_diff.sv =====
// A read passes through the memory read register and the output register to its result.
// A scan's first row takes the same path; rows then follow at one row per cycle while the
// result channel does not stall. A fill does one row read-modify-write per cycle; a commit
// swaps the banks. One command is in work at a time.
// Reset (synchronous, rst_n low) blanks both frames through per-row valid bits at once.
module double_buffered_color_frame_diff #(
  parameter int MAX_COLS   = dbcfd_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = dbcfd_pkg::MAX_ROWS_DEF,
  parameter int COLOR_BITS = dbcfd_pkg::COLOR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dbcfd_in_if.sink    in_ch,
  dbcfd_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int ROW_W = MAX_COLS * COLOR_BITS;
  localparam int LIM_C = (MAX_COLS < dbcfd_pkg::GRID_LIMIT) ? MAX_COLS : dbcfd_pkg::GRID_LIMIT;
  localparam int LIM_R = (MAX_ROWS < dbcfd_pkg::GRID_LIMIT) ? MAX_ROWS : dbcfd_pkg::GRID_LIMIT;

  dbcfd_pkg::state_t    state_r, state_nxt;
  dbcfd_pkg::mem_ctl_t  ctl;
  dbcfd_pkg::out_item_t out_item_r, out_item_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [5:0]           cols_cfg_r, rows_cfg_r;
  logic [5:0]           cols, rows;
  logic [5:0]           y_r, y_nxt;
  logic [4:0]           px_r;
  logic [5:0]           xe_r;
  logic [5:0]           ye_r;
  logic [3:0]           color_r;
  logic                 oor_r;
  logic [6:0]           xe_sum, ye_sum;
  logic [5:0]           xe_in, ye_in;
  logic                 fill_empty;
  logic                 oor_in;
  logic                 in_acc;
  logic                 can_load;
  logic                 scan_last;
  logic [ROW_W-1:0]     cur_row, prev_row, wr_row;
  logic [31:0]          change_mask;
  logic [3:0]           cell_color;

  // A zero dimension acts as one; anything above the storage or mask limit is cut back to it.
  always_comb begin
    if (cols_cfg_r == 6'd0) begin
      cols = 6'd1;
    end else if (cols_cfg_r > 6'(LIM_C)) begin
      cols = 6'(LIM_C);
    end else begin
      cols = cols_cfg_r;
    end
    if (rows_cfg_r == 6'd0) begin
      rows = 6'd1;
    end else if (rows_cfg_r > 6'(LIM_R)) begin
      rows = 6'(LIM_R);
    end else begin
      rows = rows_cfg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= dbcfd_pkg::COLS_RESET;
      rows_cfg_r <= dbcfd_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dbcfd_pkg::CFG_COLS: cols_cfg_r <= cfg_data;
        dbcfd_pkg::CFG_ROWS: rows_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == dbcfd_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Clip the rectangle end points to the grid in use.
  assign xe_sum     = 7'(in_ch.item.pos_x) + 7'(in_ch.item.rect_width);
  assign ye_sum     = 7'(in_ch.item.pos_y) + 7'(in_ch.item.rect_height);
  assign xe_in      = (xe_sum > 7'(cols)) ? cols : xe_sum[5:0];
  assign ye_in      = (ye_sum > 7'(rows)) ? rows : ye_sum[5:0];
  assign fill_empty = (xe_in <= 6'(in_ch.item.pos_x)) || (ye_in <= 6'(in_ch.item.pos_y));
  assign oor_in     = (6'(in_ch.item.pos_x) >= cols) || (6'(in_ch.item.pos_y) >= rows);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r    <= in_ch.item.pos_x;
      xe_r    <= xe_in;
      ye_r    <= ye_in;
      color_r <= in_ch.item.fill_color;
      oor_r   <= oor_in;
    end
  end

  assign can_load  = !out_valid_r || out_ch.ready;
  assign scan_last = (6'(y_r + 6'd1) == rows);

  always_comb begin
    state_nxt     = state_r;
    y_nxt         = y_r;
    ctl           = '0;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      dbcfd_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_ch.item.kind)
            dbcfd_pkg::KIND_FILL: begin
              if (!fill_empty) begin
                ctl.rd_en  = 1'b1;
                ctl.rd_row = 6'(in_ch.item.pos_y);
                y_nxt      = 6'(in_ch.item.pos_y);
                state_nxt  = dbcfd_pkg::S_FILL;
              end
            end
            dbcfd_pkg::KIND_READ: begin
              ctl.rd_en  = 1'b1;
              ctl.rd_row = 6'(in_ch.item.pos_y);
              state_nxt  = dbcfd_pkg::S_READ;
            end
            dbcfd_pkg::KIND_COMMIT: begin
              ctl.commit = 1'b1;
            end
            dbcfd_pkg::KIND_SCAN: begin
              ctl.rd_en  = 1'b1;
              ctl.rd_row = 6'd0;
              y_nxt      = 6'd0;
              state_nxt  = dbcfd_pkg::S_SCAN;
            end
            default: ;
          endcase
        end
      end
      dbcfd_pkg::S_FILL: begin
        // Write back the merged row while fetching the next one.
        ctl.wr_en  = 1'b1;
        ctl.wr_row = y_r;
        if (6'(y_r + 6'd1) < ye_r) begin
          ctl.rd_en  = 1'b1;
          ctl.rd_row = 6'(y_r + 6'd1);
          y_nxt      = 6'(y_r + 6'd1);
        end else begin
          state_nxt = dbcfd_pkg::S_IDLE;
        end
      end
      dbcfd_pkg::S_READ: begin
        if (can_load) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt              = '0;
          out_item_nxt.read_color   = oor_r ? dbcfd_pkg::BLACK : cell_color;
          out_item_nxt.out_of_range = oor_r;
          out_item_nxt.last         = 1'b1;
          state_nxt                 = dbcfd_pkg::S_IDLE;
        end
      end
      dbcfd_pkg::S_SCAN: begin
        if (can_load) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt             = '0;
          out_item_nxt.row_index   = y_r[4:0];
          out_item_nxt.change_mask = change_mask;
          out_item_nxt.last        = scan_last;
          if (scan_last) begin
            state_nxt = dbcfd_pkg::S_IDLE;
          end else begin
            ctl.rd_en  = 1'b1;
            ctl.rd_row = 6'(y_r + 6'd1);
            y_nxt      = 6'(y_r + 6'd1);
          end
        end
      end
      default: begin
        state_nxt = dbcfd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dbcfd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      y_r         <= 6'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      y_r         <= y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

  dbcfd_frame_mem #(
    .MAX_ROWS (MAX_ROWS),
    .ROW_W    (ROW_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .wr_data  (wr_row),
    .cur_row  (cur_row),
    .prev_row (prev_row)
  );

  dbcfd_row_unit #(
    .MAX_COLS   (MAX_COLS),
    .COLOR_BITS (COLOR_BITS)
  ) u_row (
    .cur_row     (cur_row),
    .prev_row    (prev_row),
    .px          (px_r),
    .xe          (xe_r),
    .cols        (cols),
    .fill_color  (color_r),
    .wr_row      (wr_row),
    .change_mask (change_mask),
    .cell_color  (cell_color)
  );

`ifndef SYNTH
  a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (6'(out_ch.item.row_index) < rows))
    else $error("result row index outside the grid in use");

  a_fill_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dbcfd_pkg::S_FILL) |-> (y_r < ye_r))
    else $error("fill row beyond the clipped rectangle");

  a_scan_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dbcfd_pkg::S_SCAN) |-> (y_r < rows))
    else $error("scan row beyond the grid in use");

  a_oor_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.item.out_of_range) |->
      (out_ch.item.read_color == dbcfd_pkg::BLACK && out_ch.item.change_mask == 32'd0))
    else $error("out-of-range read carries a color or mask");
`endif

endmodule
